[design/gb3_pkg.sv]
// Shared constants, codes and types of the 3x3 Gaussian blur core.
`default_nettype none

package gb3_pkg;

   // Line store and position sizing
   localparam int MAX_WIDTH   = 1024;
   localparam int WIDTH_CAP   = 1024;
   localparam int LINE_DEPTH  = (MAX_WIDTH < WIDTH_CAP) ? MAX_WIDTH : WIDTH_CAP;
   localparam int COL_BITS    = $clog2(LINE_DEPTH);
   localparam int HEIGHT_CAP  = 4096;
   localparam int ROW_BITS    = 13;
   localparam logic [ROW_BITS-1:0] ROW_LIMIT = ROW_BITS'(8191);
   localparam int LEFT_BITS   = 23;

   // Configuration field widths
   localparam int CFG_WIDTH_BITS  = 11;
   localparam int CFG_HEIGHT_BITS = 13;
   localparam int WEIGHT_BITS     = 16;

   // Datapath widths
   localparam int PIXEL_BITS  = 8;
   localparam int LINE_BITS   = 2 * PIXEL_BITS;
   localparam int WIN_SIZE    = 9;
   localparam int SUM_BITS    = PIXEL_BITS + 2;
   localparam int PROD_C_BITS = WEIGHT_BITS + PIXEL_BITS;
   localparam int PROD_S_BITS = WEIGHT_BITS + SUM_BITS;
   localparam int ACC_BITS    = WEIGHT_BITS + SUM_BITS + 2;
   localparam int SCALED_BITS = ACC_BITS - WEIGHT_BITS;
   localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (WEIGHT_BITS - 1);
   localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = '1;

   // Item kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // Register file
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 3;
   localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = REG_IDX_BITS'(0);
   localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = REG_IDX_BITS'(1);
   localparam logic [REG_IDX_BITS-1:0] REG_CENTER_WEIGHT = REG_IDX_BITS'(2);
   localparam logic [REG_IDX_BITS-1:0] REG_EDGE_WEIGHT   = REG_IDX_BITS'(3);
   localparam logic [REG_IDX_BITS-1:0] REG_CORNER_WEIGHT = REG_IDX_BITS'(4);

   localparam logic [CFG_WIDTH_BITS-1:0]  RESET_WIDTH  = CFG_WIDTH_BITS'(512);
   localparam logic [CFG_HEIGHT_BITS-1:0] RESET_HEIGHT = CFG_HEIGHT_BITS'(512);
   localparam logic [WEIGHT_BITS-1:0]     RESET_CENTER = WEIGHT_BITS'(7836);
   localparam logic [WEIGHT_BITS-1:0]     RESET_EDGE   = WEIGHT_BITS'(7413);
   localparam logic [WEIGHT_BITS-1:0]     RESET_CORNER = WEIGHT_BITS'(7012);

   // Queues
   localparam int OPQ_DEPTH      = 4;
   localparam int OPQ_PTR_BITS   = $clog2(OPQ_DEPTH);
   localparam int OPQ_CNT_BITS   = $clog2(OPQ_DEPTH + 1);
   localparam int OUTQ_DEPTH     = 8;
   localparam int OUTQ_PTR_BITS  = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_BITS  = $clog2(OUTQ_DEPTH + 1);
   localparam int INFLIGHT_BITS  = 2;

   typedef struct packed {
      logic [CFG_WIDTH_BITS-1:0]  image_width;
      logic [CFG_HEIGHT_BITS-1:0] image_height;
      logic [WEIGHT_BITS-1:0]     center_weight;
      logic [WEIGHT_BITS-1:0]     edge_weight;
      logic [WEIGHT_BITS-1:0]     corner_weight;
   } gb3_cfg_type;

   // One classified item for the back end
   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic [COL_BITS-1:0]   col;
      logic                  col_first;
      logic                  row_ge1;
      logic                  row_ge2;
      logic                  emit;
      logic                  last;
   } gb3_op_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  last;
   } gb3_result_type;

endpackage

`default_nettype wire

[design/gb3_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gb3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/gb3_front.sv]
// Front end: accepts items, tracks frame position and classifies each item.
`default_nettype none

module gb3_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gb3_pkg::gb3_cfg_type          cfg,
   input  wire logic                          req_push,
   input  wire logic                          req_kind,
   input  wire logic [gb3_pkg::PIXEL_BITS-1:0] req_pixel_in,
   input  wire logic                          queue_full,
   output logic                               op_push,
   output gb3_pkg::gb3_op_type                op
);

   logic [gb3_pkg::COL_BITS-1:0]        col_ff, col_in;
   logic [gb3_pkg::ROW_BITS-1:0]        row_ff, row_in;
   logic [gb3_pkg::LEFT_BITS-1:0]       left_ff, left_in;

   logic [gb3_pkg::CFG_WIDTH_BITS-1:0]  width_eff;
   logic [gb3_pkg::CFG_HEIGHT_BITS-1:0] height_eff;
   logic [gb3_pkg::LEFT_BITS-1:0]       frame_size;
   logic                                wrap_now;
   logic [gb3_pkg::COL_BITS-1:0]        col_cur;
   logic [gb3_pkg::ROW_BITS-1:0]        row_cur;
   logic [gb3_pkg::LEFT_BITS-1:0]       left_cur;
   logic [gb3_pkg::LEFT_BITS-1:0]       left_dec;
   logic [gb3_pkg::CFG_WIDTH_BITS-1:0]  col_inc;
   logic                                emit;
   logic                                last;

   function automatic logic [gb3_pkg::ROW_BITS-1:0] row_step(
      input logic [gb3_pkg::ROW_BITS-1:0] row
   );
      return (row == gb3_pkg::ROW_LIMIT) ? row : row + gb3_pkg::ROW_BITS'(1);
   endfunction

   // Clamp frame size to the supported range
   always_comb begin
      if (cfg.image_width == '0) begin
         width_eff = gb3_pkg::CFG_WIDTH_BITS'(1);
      end else if (cfg.image_width > gb3_pkg::CFG_WIDTH_BITS'(gb3_pkg::LINE_DEPTH)) begin
         width_eff = gb3_pkg::CFG_WIDTH_BITS'(gb3_pkg::LINE_DEPTH);
      end else begin
         width_eff = cfg.image_width;
      end
      if (cfg.image_height == '0) begin
         height_eff = gb3_pkg::CFG_HEIGHT_BITS'(1);
      end else if (cfg.image_height > gb3_pkg::CFG_HEIGHT_BITS'(gb3_pkg::HEIGHT_CAP)) begin
         height_eff = gb3_pkg::CFG_HEIGHT_BITS'(gb3_pkg::HEIGHT_CAP);
      end else begin
         height_eff = cfg.image_height;
      end
   end

   assign frame_size = gb3_pkg::LEFT_BITS'(width_eff) * gb3_pkg::LEFT_BITS'(height_eff);

   // Position of this item, after a wrap left pending by a narrower width
   assign wrap_now = gb3_pkg::CFG_WIDTH_BITS'(col_ff) >= width_eff;
   assign col_cur  = wrap_now ? '0 : col_ff;
   assign row_cur  = wrap_now ? row_step(row_ff) : row_ff;
   assign left_cur = (row_cur == '0 && col_cur == '0) ? frame_size : left_ff;
   assign left_dec = left_cur - gb3_pkg::LEFT_BITS'(1);

   // Classify the item
   assign emit = ((col_cur == '0) ? (row_cur[gb3_pkg::ROW_BITS-1:1] != '0)
                                  : (row_cur != '0)) && (left_cur != '0);
   assign last = emit && (left_dec == '0);

   always_comb begin
      op.pixel     = (req_kind == gb3_pkg::KIND_FLUSH ||
                      row_cur >= gb3_pkg::ROW_BITS'(height_eff)) ? '0 : req_pixel_in;
      op.col       = col_cur;
      op.col_first = (col_cur == '0);
      op.row_ge1   = (row_cur != '0);
      op.row_ge2   = (row_cur[gb3_pkg::ROW_BITS-1:1] != '0);
      op.emit      = emit;
      op.last      = last;
   end

   assign op_push = req_push && !queue_full;

   // Advance the position; return to the frame start after the last output
   always_comb begin
      col_inc = gb3_pkg::CFG_WIDTH_BITS'(col_cur) + gb3_pkg::CFG_WIDTH_BITS'(1);
      if (col_inc >= width_eff) begin
         col_in = '0;
         row_in = row_step(row_cur);
      end else begin
         col_in = gb3_pkg::COL_BITS'(col_inc);
         row_in = row_cur;
      end
      if (last) begin
         col_in = '0;
         row_in = '0;
      end
      left_in = emit ? left_dec : left_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         left_ff <= '0;
      end else if (op_push) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         left_ff <= left_in;
      end
   end

endmodule

`default_nettype wire

[design/gb3_op_queue.sv]
// Short queue of classified items between the front and back ends.
`default_nettype none

module gb3_op_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire gb3_pkg::gb3_op_type  push_data,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      empty,
   output gb3_pkg::gb3_op_type       head
);

   gb3_pkg::gb3_op_type               entry_ff [gb3_pkg::OPQ_DEPTH];
   logic [gb3_pkg::OPQ_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [gb3_pkg::OPQ_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [gb3_pkg::OPQ_CNT_BITS-1:0]  count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign full    = (count_ff == gb3_pkg::OPQ_CNT_BITS'(gb3_pkg::OPQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == gb3_pkg::OPQ_PTR_BITS'(gb3_pkg::OPQ_DEPTH - 1))
                     ? '0 : wr_ptr_ff + gb3_pkg::OPQ_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == gb3_pkg::OPQ_PTR_BITS'(gb3_pkg::OPQ_DEPTH - 1))
                     ? '0 : rd_ptr_ff + gb3_pkg::OPQ_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + gb3_pkg::OPQ_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - gb3_pkg::OPQ_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[design/gb3_back.sv]
// Back end: line store, 3x3 window and the weighted-sum filter pipeline.
`default_nettype none

module gb3_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire gb3_pkg::gb3_cfg_type              cfg,
   input  wire logic                              op_valid,
   input  wire gb3_pkg::gb3_op_type               op,
   output logic                                   op_pop,
   input  wire logic [gb3_pkg::OUTQ_CNT_BITS-1:0] out_count,
   output logic                                   res_valid,
   output gb3_pkg::gb3_result_type                res
);

   // Line store stage
   logic                             a_valid_ff;
   gb3_pkg::gb3_op_type              a_op_ff;
   logic                             fwd_hit_ff, fwd_hit_in;
   logic [gb3_pkg::LINE_BITS-1:0]    fwd_data_ff;
   logic [gb3_pkg::LINE_BITS-1:0]    ram_rdata;
   logic [gb3_pkg::LINE_BITS-1:0]    line_rd;
   logic [gb3_pkg::LINE_BITS-1:0]    line_wr;
   logic [gb3_pkg::PIXEL_BITS-1:0]   upper_pix;
   logic [gb3_pkg::PIXEL_BITS-1:0]   lower_pix;
   logic [gb3_pkg::PIXEL_BITS-1:0]   new_col [3];
   logic [gb3_pkg::PIXEL_BITS-1:0]   win_ff [gb3_pkg::WIN_SIZE];
   logic [gb3_pkg::PIXEL_BITS-1:0]   win_in [gb3_pkg::WIN_SIZE];
   logic [gb3_pkg::PIXEL_BITS-1:0]   win_sh [gb3_pkg::WIN_SIZE];

   // Sum stage
   logic                             c_valid_ff;
   logic                             c_last_ff;
   logic [gb3_pkg::PIXEL_BITS-1:0]   c_center_ff;
   logic [gb3_pkg::SUM_BITS-1:0]     c_edges_ff, c_edges_in;
   logic [gb3_pkg::SUM_BITS-1:0]     c_corners_ff, c_corners_in;

   // Product stage
   logic                             d_valid_ff;
   logic                             d_last_ff;
   logic [gb3_pkg::PROD_C_BITS-1:0]  d_prod_c_ff;
   logic [gb3_pkg::PROD_S_BITS-1:0]  d_prod_e_ff;
   logic [gb3_pkg::PROD_S_BITS-1:0]  d_prod_k_ff;

   logic [gb3_pkg::ACC_BITS-1:0]     acc;
   logic [gb3_pkg::SCALED_BITS-1:0]  scaled;
   logic [gb3_pkg::INFLIGHT_BITS-1:0] inflight;
   logic [gb3_pkg::OUTQ_CNT_BITS:0]  credit_used;

   // Take an item only when the output queue has room for everything in flight
   assign inflight = gb3_pkg::INFLIGHT_BITS'(a_valid_ff && a_op_ff.emit)
                   + gb3_pkg::INFLIGHT_BITS'(c_valid_ff)
                   + gb3_pkg::INFLIGHT_BITS'(d_valid_ff);
   assign credit_used = (gb3_pkg::OUTQ_CNT_BITS+1)'(out_count)
                      + (gb3_pkg::OUTQ_CNT_BITS+1)'(inflight);
   assign op_pop = op_valid &&
                   (credit_used < (gb3_pkg::OUTQ_CNT_BITS+1)'(gb3_pkg::OUTQ_DEPTH));

   // Upper row in the high byte, lower row in the low byte
   gb3_ram #(
      .WIDTH (gb3_pkg::LINE_BITS),
      .DEPTH (gb3_pkg::LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (a_valid_ff),
      .wr_addr (a_op_ff.col),
      .wr_data (line_wr),
      .rd_en   (op_pop),
      .rd_addr (op.col),
      .rd_data (ram_rdata)
   );

   // Forward the line written in the same cycle as a read of that column
   assign fwd_hit_in = op_pop && a_valid_ff && (op.col == a_op_ff.col);
   assign line_rd    = fwd_hit_ff ? fwd_data_ff : ram_rdata;
   assign upper_pix  = line_rd[gb3_pkg::LINE_BITS-1:gb3_pkg::PIXEL_BITS];
   assign lower_pix  = line_rd[gb3_pkg::PIXEL_BITS-1:0];
   assign line_wr    = {lower_pix, a_op_ff.pixel};

   // Shift the window; a row start feeds a zero column before it is rebuilt
   always_comb begin
      if (a_op_ff.col_first) begin
         new_col[0] = '0;
         new_col[1] = '0;
         new_col[2] = '0;
      end else begin
         new_col[0] = a_op_ff.row_ge2 ? upper_pix : '0;
         new_col[1] = a_op_ff.row_ge1 ? lower_pix : '0;
         new_col[2] = a_op_ff.pixel;
      end
      for (int r = 0; r < 3; r++) begin
         win_sh[r*3]     = win_ff[r*3 + 1];
         win_sh[r*3 + 1] = win_ff[r*3 + 2];
         win_sh[r*3 + 2] = new_col[r];
      end
      if (a_op_ff.col_first) begin
         for (int i = 0; i < gb3_pkg::WIN_SIZE; i++) begin
            win_in[i] = '0;
         end
         win_in[2] = a_op_ff.row_ge2 ? upper_pix : '0;
         win_in[5] = a_op_ff.row_ge1 ? lower_pix : '0;
         win_in[8] = a_op_ff.pixel;
      end else begin
         win_in = win_sh;
      end
   end

   // Sum the edge and corner neighbors of the shifted window
   assign c_edges_in = gb3_pkg::SUM_BITS'(win_sh[1]) + gb3_pkg::SUM_BITS'(win_sh[3])
                     + gb3_pkg::SUM_BITS'(win_sh[5]) + gb3_pkg::SUM_BITS'(win_sh[7]);
   assign c_corners_in = gb3_pkg::SUM_BITS'(win_sh[0]) + gb3_pkg::SUM_BITS'(win_sh[2])
                       + gb3_pkg::SUM_BITS'(win_sh[6]) + gb3_pkg::SUM_BITS'(win_sh[8]);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         fwd_hit_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         for (int i = 0; i < gb3_pkg::WIN_SIZE; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         a_valid_ff <= op_pop;
         fwd_hit_ff <= fwd_hit_in;
         c_valid_ff <= a_valid_ff && a_op_ff.emit;
         d_valid_ff <= c_valid_ff;
         if (a_valid_ff) begin
            win_ff <= win_in;
         end
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (op_pop) begin
         a_op_ff <= op;
      end
      if (fwd_hit_in) begin
         fwd_data_ff <= line_wr;
      end
      if (a_valid_ff) begin
         c_last_ff    <= a_op_ff.last;
         c_center_ff  <= win_sh[4];
         c_edges_ff   <= c_edges_in;
         c_corners_ff <= c_corners_in;
      end
      if (c_valid_ff) begin
         d_last_ff   <= c_last_ff;
         d_prod_c_ff <= gb3_pkg::PROD_C_BITS'(cfg.center_weight)
                      * gb3_pkg::PROD_C_BITS'(c_center_ff);
         d_prod_e_ff <= gb3_pkg::PROD_S_BITS'(cfg.edge_weight)
                      * gb3_pkg::PROD_S_BITS'(c_edges_ff);
         d_prod_k_ff <= gb3_pkg::PROD_S_BITS'(cfg.corner_weight)
                      * gb3_pkg::PROD_S_BITS'(c_corners_ff);
      end
   end

   // Add, round half up and saturate
   assign acc = gb3_pkg::ACC_BITS'(d_prod_c_ff) + gb3_pkg::ACC_BITS'(d_prod_e_ff)
              + gb3_pkg::ACC_BITS'(d_prod_k_ff) + gb3_pkg::ROUND_HALF;
   assign scaled = acc[gb3_pkg::ACC_BITS-1:gb3_pkg::WEIGHT_BITS];

   assign res_valid = d_valid_ff;
   always_comb begin
      res.pixel = (scaled[gb3_pkg::SCALED_BITS-1:gb3_pkg::PIXEL_BITS] != '0)
                  ? gb3_pkg::PIXEL_MAX : scaled[gb3_pkg::PIXEL_BITS-1:0];
      res.last  = d_last_ff;
   end

endmodule

`default_nettype wire

[design/gb3_out_queue.sv]
// Result queue that decouples the filter pipeline from the consumer.
`default_nettype none

module gb3_out_queue (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   input  wire gb3_pkg::gb3_result_type            push_data,
   input  wire logic                               pop,
   output logic                                    empty,
   output gb3_pkg::gb3_result_type                 head,
   output logic [gb3_pkg::OUTQ_CNT_BITS-1:0]       count
);

   gb3_pkg::gb3_result_type            entry_ff [gb3_pkg::OUTQ_DEPTH];
   logic [gb3_pkg::OUTQ_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [gb3_pkg::OUTQ_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [gb3_pkg::OUTQ_CNT_BITS-1:0]  count_ff, count_in;
   logic                               do_pop;

   assign empty  = (count_ff == '0);
   assign head   = entry_ff[rd_ptr_ff];
   assign count  = count_ff;
   assign do_pop = pop && !empty;

   // Advance pointers and count; the pipeline never pushes into a full queue
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == gb3_pkg::OUTQ_PTR_BITS'(gb3_pkg::OUTQ_DEPTH - 1))
                     ? '0 : wr_ptr_ff + gb3_pkg::OUTQ_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == gb3_pkg::OUTQ_PTR_BITS'(gb3_pkg::OUTQ_DEPTH - 1))
                     ? '0 : rd_ptr_ff + gb3_pkg::OUTQ_PTR_BITS'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + gb3_pkg::OUTQ_CNT_BITS'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - gb3_pkg::OUTQ_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the result
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[design/gaussian_blur_3x3_core.sv]
// Top level of the streaming 3x3 Gaussian blur: register file and queue wiring.
// Path: a result shows on the rsp ports after the transfer of the item that
//   completes its window (one row plus one pixel after its own pixel).
// Throughput: one item per cycle while the result queue has room, set by the line store RAM.
// Reset: registers return to their defaults, position and queues clear; the
//   line store keeps its contents and needs no clearing pass.
`default_nettype none

module gaussian_blur_3x3_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic                                req_kind,
   input  wire logic [gb3_pkg::PIXEL_BITS-1:0]      req_pixel_in,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic      [gb3_pkg::PIXEL_BITS-1:0]      rsp_pixel_out,
   output logic                                     rsp_last_of_frame,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [gb3_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [gb3_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [gb3_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                     csr_pready
);

   gb3_pkg::gb3_cfg_type                  cfg_ff, cfg_in;
   logic [gb3_pkg::REG_IDX_BITS-1:0]      reg_idx;
   logic                                  csr_write;

   logic                                  op_push;
   gb3_pkg::gb3_op_type                   op_front;
   logic                                  opq_full;
   logic                                  opq_empty;
   gb3_pkg::gb3_op_type                   op_head;
   logic                                  op_pop;
   logic                                  res_valid;
   gb3_pkg::gb3_result_type               res;
   gb3_pkg::gb3_result_type               out_head;
   logic [gb3_pkg::OUTQ_CNT_BITS-1:0]     out_count;

   assign reg_idx    = csr_paddr[gb3_pkg::CSR_ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_idx)
            gb3_pkg::REG_IMAGE_WIDTH: begin
               cfg_in.image_width = csr_pwdata[gb3_pkg::CFG_WIDTH_BITS-1:0];
            end
            gb3_pkg::REG_IMAGE_HEIGHT: begin
               cfg_in.image_height = csr_pwdata[gb3_pkg::CFG_HEIGHT_BITS-1:0];
            end
            gb3_pkg::REG_CENTER_WEIGHT: begin
               cfg_in.center_weight = csr_pwdata[gb3_pkg::WEIGHT_BITS-1:0];
            end
            gb3_pkg::REG_EDGE_WEIGHT: begin
               cfg_in.edge_weight = csr_pwdata[gb3_pkg::WEIGHT_BITS-1:0];
            end
            gb3_pkg::REG_CORNER_WEIGHT: begin
               cfg_in.corner_weight = csr_pwdata[gb3_pkg::WEIGHT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= gb3_pkg::RESET_WIDTH;
         cfg_ff.image_height  <= gb3_pkg::RESET_HEIGHT;
         cfg_ff.center_weight <= gb3_pkg::RESET_CENTER;
         cfg_ff.edge_weight   <= gb3_pkg::RESET_EDGE;
         cfg_ff.corner_weight <= gb3_pkg::RESET_CORNER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read-back
   always_comb begin
      unique case (reg_idx)
         gb3_pkg::REG_IMAGE_WIDTH:   csr_prdata = gb3_pkg::CSR_DATA_BITS'(cfg_ff.image_width);
         gb3_pkg::REG_IMAGE_HEIGHT:  csr_prdata = gb3_pkg::CSR_DATA_BITS'(cfg_ff.image_height);
         gb3_pkg::REG_CENTER_WEIGHT: csr_prdata = gb3_pkg::CSR_DATA_BITS'(cfg_ff.center_weight);
         gb3_pkg::REG_EDGE_WEIGHT:   csr_prdata = gb3_pkg::CSR_DATA_BITS'(cfg_ff.edge_weight);
         gb3_pkg::REG_CORNER_WEIGHT: csr_prdata = gb3_pkg::CSR_DATA_BITS'(cfg_ff.corner_weight);
         default:                    csr_prdata = '0;
      endcase
   end

   assign req_full = opq_full;

   gb3_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_push     (req_push),
      .req_kind     (req_kind),
      .req_pixel_in (req_pixel_in),
      .queue_full   (opq_full),
      .op_push      (op_push),
      .op           (op_front)
   );

   gb3_op_queue u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_front),
      .pop       (op_pop),
      .full      (opq_full),
      .empty     (opq_empty),
      .head      (op_head)
   );

   gb3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .op_valid  (!opq_empty),
      .op        (op_head),
      .op_pop    (op_pop),
      .out_count (out_count),
      .res_valid (res_valid),
      .res       (res)
   );

   gb3_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (out_head),
      .count     (out_count)
   );

   assign rsp_pixel_out     = out_head.pixel;
   assign rsp_last_of_frame = out_head.last;

endmodule

`default_nettype wire
